[sv/assert_macros.svh]
// Assertion macros shared by the checker modules of the escape sequence parser.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[sv/aesp_pkg.sv]
// Shared types, codes, constants and helper functions of the escape sequence parser.
// Depends on nothing.
package aesp_pkg;

   localparam int MaxSeqLen = 25;
   localparam int MaxParams = 16;
   localparam int ResultCap = 16;
   localparam int CAP_W     = 5;

   localparam logic [13:0] PARAM_MAX = 14'd9999;

   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_ENQ  = 8'h05;
   localparam logic [7:0] CH_BEL  = 8'h07;
   localparam logic [7:0] CH_BS   = 8'h08;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_SO   = 8'h0E;
   localparam logic [7:0] CH_SI   = 8'h0F;
   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_CSI  = 8'h9B;

   localparam logic [4:0] EV_PRINT      = 5'd0;
   localparam logic [4:0] EV_BELL       = 5'd1;
   localparam logic [4:0] EV_LEFT       = 5'd2;
   localparam logic [4:0] EV_NEWLINE    = 5'd3;
   localparam logic [4:0] EV_CR         = 5'd4;
   localparam logic [4:0] EV_UP         = 5'd5;
   localparam logic [4:0] EV_DOWN       = 5'd6;
   localparam logic [4:0] EV_RIGHT      = 5'd7;
   localparam logic [4:0] EV_GOTO       = 5'd8;
   localparam logic [4:0] EV_ERASE_DISP = 5'd9;
   localparam logic [4:0] EV_ERASE_LINE = 5'd10;
   localparam logic [4:0] EV_INSERT     = 5'd11;
   localparam logic [4:0] EV_DELETE     = 5'd12;
   localparam logic [4:0] EV_SCROLL     = 5'd13;
   localparam logic [4:0] EV_SAVE       = 5'd14;
   localparam logic [4:0] EV_RESTORE    = 5'd15;
   localparam logic [4:0] EV_MODE       = 5'd16;
   localparam logic [4:0] EV_PMODE      = 5'd17;
   localparam logic [4:0] EV_SGR        = 5'd18;
   localparam logic [4:0] EV_VBELL      = 5'd19;
   localparam logic [4:0] EV_NH         = 5'd20;

   typedef struct packed {
      logic        final_cmd;
      logic        pair;
      logic [4:0]  code;
      logic [13:0] arg;
   } cmd_type;

   typedef struct packed {
      logic [4:0]  code;
      logic [13:0] arg_a;
      logic [13:0] arg_b;
      logic        last;
   } ev_type;

   function automatic logic ansi_mode_ok(input logic [13:0] v);
      return v == 14'd2 || v == 14'd4 || v == 14'd12 || v == 14'd20;
   endfunction

   function automatic logic priv_mode_ok(input logic [13:0] v);
      return (v >= 14'd1 && v <= 14'd7 && v != 14'd2) || v == 14'd25;
   endfunction

   function automatic logic sgr_ok(input logic [13:0] v);
      return v == 14'd0 || v == 14'd1 || v == 14'd4 || v == 14'd5 || v == 14'd7 ||
             v == 14'd8 || (v >= 14'd30 && v <= 14'd49);
   endfunction

endpackage

[sv/aesp_front.sv]
// Front end of the escape sequence parser: byte intake, phase tracking and parameter store.
// Depends on aesp_pkg; feeds aesp_queue and is read by aesp_back.
module aesp_front #(
   parameter int MAX_SEQ_LEN = aesp_pkg::MaxSeqLen,
   parameter int MAX_PARAMS  = aesp_pkg::MaxParams
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [7:0]                          req_rx_byte,
   output logic                                req_ready,
   input  logic                                q_full,
   output logic                                push,
   output aesp_pkg::cmd_type                   push_cmd,
   input  logic                                final_done,
   input  logic [$clog2(MAX_PARAMS)-1:0]       rd_idx,
   output logic [13:0]                         rd_value,
   output logic                                rd_priv,
   output logic [$clog2(MAX_PARAMS+1)-1:0]     pcount
);

   localparam int IW  = $clog2(MAX_PARAMS);
   localparam int PCW = $clog2(MAX_PARAMS + 1);
   localparam int SLW = $clog2(MAX_SEQ_LEN + 2);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_ESC     = 3'd1;
   localparam logic [2:0] PH_CHARSET = 3'd2;
   localparam logic [2:0] PH_START   = 3'd3;
   localparam logic [2:0] PH_PLAIN   = 3'd4;
   localparam logic [2:0] PH_PRIV    = 3'd5;

   logic [2:0]     phase_ff, phase_in;
   logic [SLW-1:0] len_ff, len_in;
   logic [PCW-1:0] pcount_ff, pcount_in;
   logic [13:0]    acc_ff, acc_in;
   logic           lock_ff, lock_in;
   logic [13:0]    rd_value_ff;
   logic           rd_priv_ff;

   logic [13:0]    mem_value [MAX_PARAMS];
   logic           mem_priv  [MAX_PARAMS];

   logic           accept;
   logic [7:0]     c;
   logic           letter;
   logic           digit;
   logic [3:0]     dval;
   logic [17:0]    grown;
   logic [SLW-1:0] len_next;
   logic           do_push;
   logic           push_priv;
   logic           wr_en;

   assign req_ready = !q_full && !lock_ff;
   assign accept    = req_valid && req_ready;
   assign c         = req_rx_byte;
   assign letter    = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   assign digit     = c >= 8'h30 && c <= 8'h39;
   assign dval      = c[3:0];
   assign grown     = 18'({acc_ff, 3'b000}) + 18'({acc_ff, 1'b0}) + 18'(dval);
   assign len_next  = len_ff + SLW'(1);
   assign wr_en     = do_push && pcount_ff < PCW'(MAX_PARAMS);
   assign rd_value  = rd_value_ff;
   assign rd_priv   = rd_priv_ff;
   assign pcount    = pcount_ff;

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      pcount_in = pcount_ff;
      acc_in    = acc_ff;
      lock_in   = lock_ff;
      push      = 1'b0;
      push_cmd  = '0;
      do_push   = 1'b0;
      push_priv = 1'b0;
      if (final_done) begin
         lock_in = 1'b0;
      end
      if (accept) begin
         priority if (c == aesp_pkg::CH_ESC) begin
            phase_in  = PH_ESC;
            len_in    = SLW'(1);
            pcount_in = '0;
            acc_in    = '0;
         end else if (c == aesp_pkg::CH_CSI) begin
            phase_in  = PH_START;
            len_in    = SLW'(2);
            pcount_in = '0;
            acc_in    = '0;
         end else if (phase_ff == PH_IDLE) begin
            push = 1'b1;
            priority case (c)
               aesp_pkg::CH_NUL, aesp_pkg::CH_ENQ,
               aesp_pkg::CH_SO, aesp_pkg::CH_SI: push = 1'b0;
               aesp_pkg::CH_BEL: push_cmd.code = aesp_pkg::EV_BELL;
               aesp_pkg::CH_BS:  push_cmd.code = aesp_pkg::EV_LEFT;
               aesp_pkg::CH_LF:  push_cmd.code = aesp_pkg::EV_NEWLINE;
               aesp_pkg::CH_CR:  push_cmd.code = aesp_pkg::EV_CR;
               default: begin
                  push_cmd.code = aesp_pkg::EV_PRINT;
                  push_cmd.arg  = 14'(c);
               end
            endcase
         end else if (phase_ff == PH_ESC) begin
            phase_in  = PH_IDLE;
            len_in    = '0;
            pcount_in = '0;
            acc_in    = '0;
            push      = 1'b1;
            priority case (c)
               8'h5B: begin
                  push     = 1'b0;
                  phase_in = PH_START;
                  len_in   = SLW'(2);
               end
               8'h28, 8'h29: begin
                  push     = 1'b0;
                  phase_in = PH_CHARSET;
                  len_in   = SLW'(2);
               end
               8'h4D: push_cmd.code = aesp_pkg::EV_UP;
               8'h44, 8'h45: begin
                  push_cmd.code = aesp_pkg::EV_CR;
                  push_cmd.pair = 1'b1;
               end
               8'h37: push_cmd.code = aesp_pkg::EV_SAVE;
               8'h38: push_cmd.code = aesp_pkg::EV_RESTORE;
               8'h67: push_cmd.code = aesp_pkg::EV_VBELL;
               default: push_cmd.code = aesp_pkg::EV_NH;
            endcase
         end else if (phase_ff == PH_START || phase_ff == PH_PLAIN ||
                      phase_ff == PH_PRIV) begin
            if (letter) begin
               do_push            = phase_ff != PH_START;
               push_priv          = phase_ff == PH_PRIV;
               push               = 1'b1;
               push_cmd.final_cmd = 1'b1;
               push_cmd.arg       = 14'(c);
               lock_in            = 1'b1;
               phase_in           = PH_IDLE;
               len_in             = '0;
               acc_in             = '0;
            end else if (len_next > SLW'(MAX_SEQ_LEN)) begin
               phase_in  = PH_IDLE;
               len_in    = '0;
               pcount_in = '0;
               acc_in    = '0;
            end else begin
               len_in = len_next;
               priority if (phase_ff == PH_START) begin
                  if (c == 8'h3F) begin
                     acc_in   = '0;
                     phase_in = PH_PRIV;
                  end else if (digit) begin
                     acc_in   = 14'(dval);
                     phase_in = PH_PLAIN;
                  end else begin
                     acc_in  = '0;
                     do_push = 1'b1;
                  end
               end else if (digit) begin
                  acc_in = (grown > 18'(aesp_pkg::PARAM_MAX)) ? aesp_pkg::PARAM_MAX
                                                               : grown[13:0];
               end else begin
                  do_push   = 1'b1;
                  push_priv = phase_ff == PH_PRIV;
                  phase_in  = PH_START;
               end
            end
         end else begin
            phase_in  = PH_IDLE;
            len_in    = '0;
            pcount_in = '0;
            acc_in    = '0;
         end
         if (do_push) begin
            acc_in = '0;
            if (wr_en) begin
               pcount_in = pcount_ff + PCW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         len_ff    <= '0;
         pcount_ff <= '0;
         acc_ff    <= '0;
         lock_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         len_ff    <= len_in;
         pcount_ff <= pcount_in;
         acc_ff    <= acc_in;
         lock_ff   <= lock_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_value[pcount_ff[IW-1:0]] <= (phase_ff == PH_START) ? 14'd0 : acc_ff;
         mem_priv[pcount_ff[IW-1:0]]  <= push_priv;
      end
      rd_value_ff <= mem_value[rd_idx];
      rd_priv_ff  <= mem_priv[rd_idx];
   end

endmodule

[sv/aesp_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on aesp_pkg for the command type.
module aesp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  aesp_pkg::cmd_type push_cmd,
   input  logic              pop,
   output aesp_pkg::cmd_type head,
   output logic              full,
   output logic              empty
);

   aesp_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/aesp_back.sv]
// Back end of the escape sequence parser: turns queued commands into display events.
// Depends on aesp_pkg; reads the parameter store of aesp_front.
module aesp_back #(
   parameter int MAX_PARAMS = aesp_pkg::MaxParams
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  aesp_pkg::cmd_type                   q_head,
   output logic                                pop,
   input  logic [$clog2(MAX_PARAMS+1)-1:0]     pcount,
   output logic [$clog2(MAX_PARAMS)-1:0]       rd_idx,
   input  logic [13:0]                         rd_value,
   input  logic                                rd_priv,
   input  logic                                out_free,
   output logic                                emit,
   output aesp_pkg::ev_type                    ev,
   output logic                                final_done
);

   localparam int IW  = $clog2(MAX_PARAMS);
   localparam int PCW = $clog2(MAX_PARAMS + 1);
   localparam int EW  = (PCW > aesp_pkg::CAP_W) ? PCW : aesp_pkg::CAP_W;

   localparam logic [2:0] B_IDLE   = 3'd0;
   localparam logic [2:0] B_SCAN   = 3'd1;
   localparam logic [2:0] B_DECIDE = 3'd2;
   localparam logic [2:0] B_ONE    = 3'd3;
   localparam logic [2:0] B_LIST   = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [PCW-1:0] idx_ff, idx_in;
   logic [PCW-1:0] np_ff, np_in;
   logic [13:0]    first_ff, first_in;
   logic [13:0]    second_ff, second_in;
   logic [7:0]     letter_ff, letter_in;
   logic [EW-1:0]  ecnt_ff, ecnt_in;
   logic [EW-1:0]  total_ff, total_in;
   logic           pass_ff, pass_in;
   logic           sgr_ff, sgr_in;
   logic           set_ff, set_in;
   logic           pair_ff, pair_in;
   logic           fin_ff, fin_in;
   logic [4:0]     code_ff, code_in;
   logic [13:0]    a_ff, a_in;
   logic [13:0]    b_ff, b_in;

   logic [EW-1:0]  pcount_ext;
   logic [EW-1:0]  np_ext;
   logic [EW-1:0]  cap_ext;
   logic           want;
   logic           ok;
   logic           idx_end;

   assign rd_idx     = idx_in[IW-1:0];
   assign pcount_ext = EW'(pcount);
   assign np_ext     = EW'(np_ff);
   assign cap_ext    = EW'(aesp_pkg::ResultCap);
   assign want       = rd_priv == pass_ff;
   assign idx_end    = idx_ff + PCW'(1) == pcount;
   assign ok         = sgr_ff ? aesp_pkg::sgr_ok(rd_value) :
                       pass_ff ? aesp_pkg::priv_mode_ok(rd_value) :
                       aesp_pkg::ansi_mode_ok(rd_value);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      np_in      = np_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      letter_in  = letter_ff;
      ecnt_in    = ecnt_ff;
      total_in   = total_ff;
      pass_in    = pass_ff;
      sgr_in     = sgr_ff;
      set_in     = set_ff;
      pair_in    = pair_ff;
      fin_in     = fin_ff;
      code_in    = code_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      pop        = 1'b0;
      emit       = 1'b0;
      ev         = '0;
      final_done = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               if (q_head.final_cmd) begin
                  letter_in = q_head.arg[7:0];
                  idx_in    = '0;
                  np_in     = '0;
                  first_in  = '0;
                  second_in = '0;
                  fin_in    = 1'b1;
                  state_in  = (pcount == '0) ? B_DECIDE : B_SCAN;
               end else begin
                  code_in  = q_head.code;
                  a_in     = q_head.arg;
                  b_in     = '0;
                  pair_in  = q_head.pair;
                  fin_in   = 1'b0;
                  state_in = B_ONE;
               end
            end
         end
         B_SCAN: begin
            if (!rd_priv) begin
               if (np_ff == PCW'(0)) begin
                  first_in = rd_value;
               end
               if (np_ff == PCW'(1)) begin
                  second_in = rd_value;
               end
               np_in = np_ff + PCW'(1);
            end
            idx_in = idx_ff + PCW'(1);
            if (idx_end) begin
               state_in = B_DECIDE;
            end
         end
         B_DECIDE: begin
            state_in = B_ONE;
            pair_in  = 1'b0;
            a_in     = '0;
            b_in     = '0;
            idx_in   = '0;
            ecnt_in  = '0;
            pass_in  = 1'b0;
            unique case (letter_ff)
               8'h48, 8'h66: begin
                  code_in = aesp_pkg::EV_GOTO;
                  a_in    = (first_ff != '0) ? first_ff - 14'd1 : 14'd0;
                  b_in    = (second_ff != '0) ? second_ff - 14'd1 : 14'd0;
               end
               8'h41: code_in = aesp_pkg::EV_UP;
               8'h42: code_in = aesp_pkg::EV_DOWN;
               8'h43: code_in = aesp_pkg::EV_RIGHT;
               8'h44: code_in = aesp_pkg::EV_LEFT;
               8'h4A, 8'h4B: begin
                  if (first_ff <= 14'd2) begin
                     code_in = (letter_ff == 8'h4A) ? aesp_pkg::EV_ERASE_DISP
                                                    : aesp_pkg::EV_ERASE_LINE;
                     a_in    = first_ff;
                  end else begin
                     code_in = aesp_pkg::EV_NH;
                  end
               end
               8'h4C, 8'h50: begin
                  code_in = (letter_ff == 8'h4C) ? aesp_pkg::EV_INSERT : aesp_pkg::EV_DELETE;
                  a_in    = (np_ff != '0) ? first_ff : 14'd1;
               end
               8'h72: begin
                  if (np_ff == PCW'(2)) begin
                     code_in = aesp_pkg::EV_SCROLL;
                     a_in    = first_ff;
                     b_in    = second_ff;
                  end else begin
                     code_in = aesp_pkg::EV_NH;
                  end
               end
               8'h73: code_in = aesp_pkg::EV_SAVE;
               8'h75: code_in = aesp_pkg::EV_RESTORE;
               8'h68, 8'h6C: begin
                  sgr_in   = 1'b0;
                  set_in   = letter_ff == 8'h68;
                  total_in = (pcount_ext > cap_ext) ? cap_ext : pcount_ext;
                  if (pcount == '0) begin
                     state_in   = B_IDLE;
                     final_done = 1'b1;
                  end else begin
                     state_in = B_LIST;
                  end
               end
               8'h6D: begin
                  if (np_ff == '0) begin
                     code_in = aesp_pkg::EV_SGR;
                  end else begin
                     sgr_in   = 1'b1;
                     set_in   = 1'b0;
                     total_in = (np_ext > cap_ext) ? cap_ext : np_ext;
                     state_in = B_LIST;
                  end
               end
               default: code_in = aesp_pkg::EV_NH;
            endcase
         end
         B_ONE: begin
            if (out_free) begin
               emit     = 1'b1;
               ev.code  = code_ff;
               ev.arg_a = a_ff;
               ev.arg_b = b_ff;
               ev.last  = !pair_ff;
               if (pair_ff) begin
                  pair_in = 1'b0;
                  code_in = aesp_pkg::EV_NEWLINE;
               end else begin
                  state_in   = B_IDLE;
                  final_done = fin_ff;
               end
            end
         end
         B_LIST: begin
            if (!want || out_free) begin
               if (want) begin
                  emit     = 1'b1;
                  ev.code  = !ok ? aesp_pkg::EV_NH :
                             sgr_ff ? aesp_pkg::EV_SGR :
                             pass_ff ? aesp_pkg::EV_PMODE : aesp_pkg::EV_MODE;
                  ev.arg_a = ok ? rd_value : 14'd0;
                  ev.arg_b = (ok && !sgr_ff) ? 14'(set_ff) : 14'd0;
                  ev.last  = ecnt_ff + EW'(1) == total_ff;
                  ecnt_in  = ecnt_ff + EW'(1);
               end
               if (want && ev.last) begin
                  state_in   = B_IDLE;
                  final_done = 1'b1;
               end else if (idx_end) begin
                  if (!pass_ff && !sgr_ff) begin
                     pass_in = 1'b1;
                     idx_in  = '0;
                  end else begin
                     state_in   = B_IDLE;
                     final_done = 1'b1;
                  end
               end else begin
                  idx_in = idx_ff + PCW'(1);
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      np_ff     <= np_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      letter_ff <= letter_in;
      ecnt_ff   <= ecnt_in;
      total_ff  <= total_in;
      pass_ff   <= pass_in;
      sgr_ff    <= sgr_in;
      set_ff    <= set_in;
      pair_ff   <= pair_in;
      fin_ff    <= fin_in;
      code_ff   <= code_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
   end

endmodule

[sv/ansi_escape_sequence_parser.sv]
// Top level of the terminal escape sequence parser: front end, command queue, back end
// and the result register. Depends on aesp_pkg, aesp_front, aesp_queue and aesp_back.
//
// Usage: received terminal bytes enter on the req_ channel (req_valid, req_ready,
// req_rx_byte); display command events leave on the rsp_ channel (rsp_valid, rsp_ready,
// event code, two arguments and a last flag marking the final event of one byte).
// Parameter bytes are taken one per cycle while the queue has room and no final letter
// is being expanded. A byte that yields a single event takes the back end through its
// idle and one-event states, so once the queue has filled such bytes are taken only as
// fast as the back end drains them. A simple event passes through the command queue,
// the back end's one-event state and the result register before it reaches rsp_valid.
// A final letter of a control sequence first scans the stored parameters, then decodes
// and emits its events; mode and attribute letters walk the parameter store again, one
// entry per cycle while the receiver takes events. The input stalls while such a letter
// is being expanded, since the back end reads the front end's parameter store.
// A stalled receiver holds the result register; the back end and then the two-entry
// command queue fill, after which req_ready drops.
// Reset returns the parser to idle and empties the queue and the result register.
module ansi_escape_sequence_parser #(
   parameter int MAX_SEQ_LEN = aesp_pkg::MaxSeqLen,
   parameter int MAX_PARAMS  = aesp_pkg::MaxParams
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_event_code,
   output logic [13:0] rsp_arg_a,
   output logic [13:0] rsp_arg_b,
   output logic        rsp_last
);

   localparam int IW  = $clog2(MAX_PARAMS);
   localparam int PCW = $clog2(MAX_PARAMS + 1);

   aesp_pkg::cmd_type push_cmd;
   aesp_pkg::cmd_type q_head;
   aesp_pkg::ev_type  ev;
   aesp_pkg::ev_type  out_ff;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_empty;
   logic              final_done;
   logic [IW-1:0]     rd_idx;
   logic [13:0]       rd_value;
   logic              rd_priv;
   logic [PCW-1:0]    pcount;
   logic              emit;
   logic              out_free;
   logic              valid_ff, valid_in;

   aesp_front #(
      .MAX_SEQ_LEN (MAX_SEQ_LEN),
      .MAX_PARAMS  (MAX_PARAMS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_ready   (req_ready),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd),
      .final_done  (final_done),
      .rd_idx      (rd_idx),
      .rd_value    (rd_value),
      .rd_priv     (rd_priv),
      .pcount      (pcount)
   );

   aesp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   aesp_back #(
      .MAX_PARAMS (MAX_PARAMS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .pop        (pop),
      .pcount     (pcount),
      .rd_idx     (rd_idx),
      .rd_value   (rd_value),
      .rd_priv    (rd_priv),
      .out_free   (out_free),
      .emit       (emit),
      .ev         (ev),
      .final_done (final_done)
   );

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= ev;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_event_code = out_ff.code;
   assign rsp_arg_a      = out_ff.arg_a;
   assign rsp_arg_b      = out_ff.arg_b;
   assign rsp_last       = out_ff.last;

endmodule

[sv/aesp_checker.sv]
// Port-level checker for the escape sequence parser, bound to the top level.
// Depends on aesp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module aesp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_event_code,
   input logic [13:0] rsp_arg_a,
   input logic [13:0] rsp_arg_b,
   input logic        rsp_last
);

   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_rx_byte), "Waiting input transaction changed.")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_code) && $stable(rsp_arg_a) && $stable(rsp_arg_b) && $stable(rsp_last), "Stalled transaction changed.")
   `ASSERT_IMPL(a_nh_args, clock, reset, rsp_valid && rsp_event_code == aesp_pkg::EV_NH, rsp_arg_a == 14'd0 && rsp_arg_b == 14'd0, "Unhandled event carries arguments.")
   `ASSERT_IMPL(a_argb_use, clock, reset, rsp_valid && rsp_arg_b != 14'd0, rsp_event_code == aesp_pkg::EV_GOTO || rsp_event_code == aesp_pkg::EV_SCROLL || ((rsp_event_code == aesp_pkg::EV_MODE || rsp_event_code == aesp_pkg::EV_PMODE) && rsp_arg_b == 14'd1), "Second argument on an event that has none.")
   `ASSERT_IMPL(a_print_arg, clock, reset, rsp_valid && rsp_event_code == aesp_pkg::EV_PRINT, rsp_arg_a <= 14'd255 && rsp_last, "Print event with a wide character.")

endmodule

bind ansi_escape_sequence_parser aesp_checker u_aesp_checker (.*);

[bench/tb_top.sv]
// Testbench for the terminal escape sequence parser: byte transactions in, event transactions out.
// Depends on aesp_pkg and ansi_escape_sequence_parser; events are checked against a local model.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;
   localparam logic [2:0] PH_IDLE = 3'd0, PH_ESC = 3'd1, PH_CHARSET = 3'd2,
                          PH_START = 3'd3, PH_PLAIN = 3'd4, PH_PRIV = 3'd5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_event_code;
   logic [13:0] rsp_arg_a;
   logic [13:0] rsp_arg_b;
   logic        rsp_last;

   ansi_escape_sequence_parser i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_event_code(rsp_event_code),
      .rsp_arg_a(rsp_arg_a), .rsp_arg_b(rsp_arg_b), .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   aesp_pkg::ev_type event_queue[$];
   logic [2:0]       mdl_phase;
   int               mdl_len;
   logic [13:0]      mdl_vals[aesp_pkg::MaxParams];
   logic             mdl_priv[aesp_pkg::MaxParams];
   int               mdl_count;
   logic [13:0]      mdl_acc;
   int               burst = 0;
   aesp_pkg::ev_type burst_evs[$];

   int  mismatches = 0;
   bit  quiet = 1'b0;
   int  idle_cycles = 0;

   function automatic void push_event(logic [4:0] c, logic [13:0] a, logic [13:0] b);
      aesp_pkg::ev_type e;
      if (burst_evs.size() >= aesp_pkg::ResultCap) return;
      e.code = c; e.arg_a = a; e.arg_b = b; e.last = 1'b0;
      burst_evs.push_back(e);
   endfunction

   function automatic void begin_seq(logic [2:0] ph, int len);
      mdl_phase = ph; mdl_len = len; mdl_count = 0; mdl_acc = 14'd0;
   endfunction

   function automatic void store_param(logic pv);
      if (mdl_count < aesp_pkg::MaxParams) begin
         mdl_vals[mdl_count] = mdl_acc;
         mdl_priv[mdl_count] = pv;
         mdl_count++;
      end
      mdl_acc = 14'd0;
   endfunction

   function automatic bit mode_valid(logic [13:0] v, bit pv);
      if (pv) return (v >= 1 && v <= 7 && v != 2) || v == 25;
      return v == 2 || v == 4 || v == 12 || v == 20;
   endfunction

   function automatic bit attr_valid(logic [13:0] v);
      return v == 0 || v == 1 || v == 4 || v == 5 || v == 7 || v == 8 || (v >= 30 && v <= 49);
   endfunction

   function automatic void expand_modes(logic [13:0] setv);
      for (int pass = 0; pass < 2; pass++)
         for (int i = 0; i < mdl_count; i++)
            if (mdl_priv[i] == pass[0]) begin
               if (mode_valid(mdl_vals[i], pass[0]))
                  push_event(pass[0] ? aesp_pkg::EV_PMODE : aesp_pkg::EV_MODE,
                             mdl_vals[i], setv);
               else
                  push_event(aesp_pkg::EV_NH, 14'd0, 14'd0);
            end
   endfunction

   function automatic void decode_final(logic [7:0] c);
      logic [13:0] pl[aesp_pkg::MaxParams];
      int np;
      logic [13:0] first;
      np = 0;
      for (int i = 0; i < mdl_count; i++)
         if (!mdl_priv[i]) begin
            pl[np] = mdl_vals[i];
            np++;
         end
      first = (np > 0) ? pl[0] : 14'd0;
      case (c)
         "H", "f": begin
            push_event(aesp_pkg::EV_GOTO, (np > 0 && pl[0] != 0) ? pl[0] - 14'd1 : 14'd0,
                       (np > 1 && pl[1] != 0) ? pl[1] - 14'd1 : 14'd0);
         end
         "A": push_event(aesp_pkg::EV_UP, 14'd0, 14'd0);
         "B": push_event(aesp_pkg::EV_DOWN, 14'd0, 14'd0);
         "C": push_event(aesp_pkg::EV_RIGHT, 14'd0, 14'd0);
         "D": push_event(aesp_pkg::EV_LEFT, 14'd0, 14'd0);
         "J": push_event(first <= 2 ? aesp_pkg::EV_ERASE_DISP : aesp_pkg::EV_NH,
                         first <= 2 ? first : 14'd0, 14'd0);
         "K": push_event(first <= 2 ? aesp_pkg::EV_ERASE_LINE : aesp_pkg::EV_NH,
                         first <= 2 ? first : 14'd0, 14'd0);
         "L": push_event(aesp_pkg::EV_INSERT, np > 0 ? pl[0] : 14'd1, 14'd0);
         "P": push_event(aesp_pkg::EV_DELETE, np > 0 ? pl[0] : 14'd1, 14'd0);
         "r": begin
            if (np == 2) push_event(aesp_pkg::EV_SCROLL, pl[0], pl[1]);
            else push_event(aesp_pkg::EV_NH, 14'd0, 14'd0);
         end
         "s": push_event(aesp_pkg::EV_SAVE, 14'd0, 14'd0);
         "u": push_event(aesp_pkg::EV_RESTORE, 14'd0, 14'd0);
         "h": expand_modes(14'd1);
         "l": expand_modes(14'd0);
         "m": begin
            if (np == 0) begin
               pl[0] = 14'd0;
               np = 1;
            end
            for (int i = 0; i < np; i++) begin
               if (attr_valid(pl[i])) push_event(aesp_pkg::EV_SGR, pl[i], 14'd0);
               else push_event(aesp_pkg::EV_NH, 14'd0, 14'd0);
            end
         end
         default: push_event(aesp_pkg::EV_NH, 14'd0, 14'd0);
      endcase
   endfunction

   function automatic void parse_byte(logic [7:0] c);
      bit letter, digit;
      int v;
      burst_evs.delete();
      letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      digit = c >= "0" && c <= "9";
      if (c == aesp_pkg::CH_ESC) begin_seq(PH_ESC, 1);
      else if (c == aesp_pkg::CH_CSI) begin_seq(PH_START, 2);
      else if (mdl_phase == PH_IDLE) begin
         case (c)
            aesp_pkg::CH_NUL, aesp_pkg::CH_ENQ, aesp_pkg::CH_SO, aesp_pkg::CH_SI: ;
            aesp_pkg::CH_BEL: push_event(aesp_pkg::EV_BELL, 14'd0, 14'd0);
            aesp_pkg::CH_BS: push_event(aesp_pkg::EV_LEFT, 14'd0, 14'd0);
            aesp_pkg::CH_LF: push_event(aesp_pkg::EV_NEWLINE, 14'd0, 14'd0);
            aesp_pkg::CH_CR: push_event(aesp_pkg::EV_CR, 14'd0, 14'd0);
            default: push_event(aesp_pkg::EV_PRINT, {6'd0, c}, 14'd0);
         endcase
      end else if (mdl_phase == PH_ESC) begin
         case (c)
            "[": begin_seq(PH_START, 2);
            "(", ")": begin_seq(PH_CHARSET, 2);
            default: begin
               case (c)
                  "M": push_event(aesp_pkg::EV_UP, 14'd0, 14'd0);
                  "D", "E": begin
                     push_event(aesp_pkg::EV_CR, 14'd0, 14'd0);
                     push_event(aesp_pkg::EV_NEWLINE, 14'd0, 14'd0);
                  end
                  "7": push_event(aesp_pkg::EV_SAVE, 14'd0, 14'd0);
                  "8": push_event(aesp_pkg::EV_RESTORE, 14'd0, 14'd0);
                  "g": push_event(aesp_pkg::EV_VBELL, 14'd0, 14'd0);
                  default: push_event(aesp_pkg::EV_NH, 14'd0, 14'd0);
               endcase
               begin_seq(PH_IDLE, 0);
            end
         endcase
      end else if (mdl_phase == PH_CHARSET) begin_seq(PH_IDLE, 0);
      else if (mdl_phase == PH_START || mdl_phase == PH_PLAIN || mdl_phase == PH_PRIV) begin
         if (letter) begin
            if (mdl_phase == PH_PLAIN) store_param(1'b0);
            else if (mdl_phase == PH_PRIV) store_param(1'b1);
            decode_final(c);
            begin_seq(PH_IDLE, 0);
         end else begin
            mdl_len++;
            if (mdl_len > aesp_pkg::MaxSeqLen) begin_seq(PH_IDLE, 0);
            else if (mdl_phase == PH_START) begin
               if (c == "?") begin
                  mdl_acc = 14'd0;
                  mdl_phase = PH_PRIV;
               end else if (digit) begin
                  mdl_acc = 14'(c - "0");
                  mdl_phase = PH_PLAIN;
               end else begin
                  mdl_acc = 14'd0;
                  store_param(1'b0);
               end
            end else if (digit) begin
               v = int'(mdl_acc) * 10 + int'(c - "0");
               mdl_acc = v > 9999 ? aesp_pkg::PARAM_MAX : 14'(v);
            end else begin
               store_param(mdl_phase == PH_PRIV);
               mdl_phase = PH_START;
            end
         end
      end else begin_seq(PH_IDLE, 0);
      if (burst_evs.size() > 0) burst_evs[burst_evs.size() - 1].last = 1'b1;
      foreach (burst_evs[i]) event_queue.push_back(burst_evs[i]);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 11);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_byte(b);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Directed table: byte strings with hand-written expectations for the simple rows.
   typedef struct {
      string       text;
      bit          typed;
      logic [4:0]  code;
      logic [13:0] a;
      logic [13:0] b;
   } row_t;

   // Receiver: random stall bursts, compares each event with the oldest expectation.
   always @(posedge clock) begin
      aesp_pkg::ev_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (event_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected event code=%0d a=%0d b=%0d last=%0b",
                        rsp_event_code, rsp_arg_a, rsp_arg_b, rsp_last);
         end else begin
            e = event_queue.pop_front();
            if (e.code !== rsp_event_code || e.arg_a !== rsp_arg_a ||
                e.arg_b !== rsp_arg_b || e.last !== rsp_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                           e.code, e.arg_a, e.arg_b, e.last,
                           rsp_event_code, rsp_arg_a, rsp_arg_b, rsp_last);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset || quiet) rsp_ready <= 1'b1;
      else if (burst > 0) begin
         burst <= burst - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         burst <= $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic string rand_num();
      case ($urandom_range(0, 5))
         0: return "";
         1: return $sformatf("%0d", $urandom_range(0, 9));
         2: return $sformatf("%0d", $urandom_range(0, 50));
         3: return $sformatf("%0d", $urandom_range(0, 99999));
         default: return $sformatf("%0d", $urandom_range(0, 30));
      endcase
   endfunction

   initial begin
      row_t rows[$];
      string finals;
      string s;
      int np;
      int sent;
      aesp_pkg::ev_type exp_e;
      finals = "HfABCDJKLPrsuhlmxZ";
      begin_seq(PH_IDLE, 0);
      rows = '{
         '{"A", 1, aesp_pkg::EV_PRINT, 14'd65, 14'd0},
         '{"\x07", 1, aesp_pkg::EV_BELL, 14'd0, 14'd0},
         '{"\x08", 1, aesp_pkg::EV_LEFT, 14'd0, 14'd0},
         '{"\n", 1, aesp_pkg::EV_NEWLINE, 14'd0, 14'd0},
         '{"\r", 1, aesp_pkg::EV_CR, 14'd0, 14'd0},
         '{"\xff", 1, aesp_pkg::EV_PRINT, 14'd255, 14'd0},
         '{"\x00\x05\x0e\x0f", 0, aesp_pkg::EV_PRINT, 14'd0, 14'd0},
         '{"\x1bH", 1, aesp_pkg::EV_NH, 14'd0, 14'd0},
         '{"\x1bM", 1, aesp_pkg::EV_UP, 14'd0, 14'd0},
         '{"\x1bD\x1bE\x1b7\x1b8\x1bg\x1b(B\x1b)0", 0, aesp_pkg::EV_PRINT, 14'd0, 14'd0},
         '{"\x1b[H", 1, aesp_pkg::EV_GOTO, 14'd0, 14'd0},
         '{"\x1b[12;40f\x1b[0;0H", 0, aesp_pkg::EV_PRINT, 14'd0, 14'd0},
         '{"\x1b[99999;1H", 1, aesp_pkg::EV_GOTO, 14'd9998, 14'd0},
         '{"\x1b[3J", 1, aesp_pkg::EV_NH, 14'd0, 14'd0},
         '{"\x1b[2K\x1b[J\x1b[1J", 0, aesp_pkg::EV_PRINT, 14'd0, 14'd0},
         '{"\x1b[L", 1, aesp_pkg::EV_INSERT, 14'd1, 14'd0},
         '{"\x1b[5P\x1b[3;20r\x1b[5r\x1b[s\x1b[u\x1b[A\x1b[B\x1b[C\x1b[D", 0,
           aesp_pkg::EV_PRINT, 14'd0, 14'd0},
         '{"\x9b4;20;7h\x9b?3;25;2;1l", 0, aesp_pkg::EV_PRINT, 14'd0, 14'd0},
         '{"\x1b[m\x1b[1;43;99;;m\x1b[?5m", 0, aesp_pkg::EV_PRINT, 14'd0, 14'd0},
         '{"\x9b1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;18m", 0,
           aesp_pkg::EV_PRINT, 14'd0, 14'd0},
         '{"\x9b1;1;1;1;1;1;1;1;1;1;1;1;1;1;1;1m", 0, aesp_pkg::EV_PRINT, 14'd0, 14'd0},
         '{"\x1b[;;;;;;;;;;;;;;;;;;;;;;;;;;;;;m", 0, aesp_pkg::EV_PRINT, 14'd0, 14'd0},
         '{"\x1b[12\x1b[3A\x1b[5\x9bq\x1b[!z", 0, aesp_pkg::EV_PRINT, 14'd0, 14'd0}
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[r]) begin
         send_text(rows[r].text);
         if (rows[r].typed) begin
            exp_e.code = rows[r].code; exp_e.arg_a = rows[r].a;
            exp_e.arg_b = rows[r].b; exp_e.last = 1'b1;
            if (burst_evs.size() != 1 || burst_evs[0] != exp_e) begin
               mismatches++;
               if (mismatches <= 10) $display("directed row %0d: predictor disagrees", r);
            end
         end
      end
      req_valid <= 1'b0;
      while (event_queue.size() > 0) @(negedge clock);
      sent = 0;
      while (sent < 95) begin
         if (sent > 75) quiet = 1'b1;
         case ($urandom_range(0, 9))
            0, 1: begin
               send_byte(8'($urandom_range(0, 255)));
               sent++;
            end
            2: begin
               send_byte(aesp_pkg::CH_ESC);
               send_byte(8'($urandom_range(0, 255)));
               send_byte(8'($urandom_range(32, 126)));
               sent += 3;
            end
            default: begin
               s = ($urandom_range(0, 1) == 0) ? "\x1b[" : "\x9b";
               np = $urandom_range(0, 5);
               for (int i = 0; i < np; i++) begin
                  if ($urandom_range(0, 4) == 0) s = {s, "?"};
                  s = {s, rand_num()};
                  if (i < np - 1) s = {s, ($urandom_range(0, 9) == 0) ? " " : ";"};
               end
               if ($urandom_range(0, 12) == 0) s = {s, "\x07"};
               s = {s, string'(finals[$urandom_range(0, finals.len() - 1)])};
               send_text(s);
               sent += s.len();
            end
         endcase
         if (sent > 40 && sent < 50) begin
            req_valid <= 1'b0;
            while (event_queue.size() > 0) @(negedge clock);
         end
      end
      req_valid <= 1'b0;
      while (event_queue.size() > 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (mismatches == 0 && event_queue.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
